// ===== hw/rtl/pps_pkg.sv =====
`default_nettype none
package pps_pkg;

  localparam int NUM_PROCS = 16;
  localparam int IDX_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CNT_W     = $clog2(NUM_PROCS + 1);
  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 8;
  localparam int SLOT_W    = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
    logic [PRIO_W-1:0] priority_req;
  } item_t;

  typedef struct packed {
    logic              tick_ran;
    logic [SLOT_W-1:0] process_slot;
    logic [TIME_W-1:0] time_now;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] response_time;
    logic              all_done;
  } result_t;

  // Slot write sent to one cell.
  typedef struct packed {
    logic              en;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } cell_wr_t;

  // Best candidate so far, passed down the chain.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] first_run;
    logic [IDX_W-1:0]  index;
  } cand_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] r;
    r = (a > b) ? (a - b) : '0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pps_cell.sv =====
`default_nettype none
module pps_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pps_pkg::IDX_W-1:0]     cell_idx_i,
  input  pps_pkg::cell_wr_t             wr_i,
  input  logic                          run_i,
  input  logic [pps_pkg::TIME_W-1:0]    time_i,
  input  pps_pkg::cand_t                cand_i,
  output pps_pkg::cand_t                cand_o,
  output logic                          idle_o
);
  import pps_pkg::*;

  logic              loaded_q, loaded_d;
  logic              done_q, done_d;
  logic [TIME_W-1:0] arrival_q, burst_q, remaining_q, first_run_q;
  logic [PRIO_W-1:0] prio_q;
  cand_t             own;
  cand_t             cand_q, cand_d;
  logic              eligible, better;

  assign idle_o = !loaded_q || done_q;

  always_comb begin
    own.valid     = 1'b1;
    own.prio      = prio_q;
    own.arrival   = arrival_q;
    own.burst     = burst_q;
    own.remaining = remaining_q;
    own.first_run = first_run_q;
    own.index     = cell_idx_i;
    eligible = loaded_q && !done_q && (arrival_q <= time_i);
    // strictly better only, so ties stay with the lower slot upstream
    better = eligible && (!cand_i.valid || (prio_q > cand_i.prio) ||
             ((prio_q == cand_i.prio) && (arrival_q < cand_i.arrival)));
    cand_d = better ? own : cand_i;
  end

  always_comb begin
    loaded_d = loaded_q;
    done_d   = done_q;
    if (wr_i.en) begin
      loaded_d = 1'b1;
      done_d   = (wr_i.burst == '0);
    end else if (run_i && (remaining_q == TIME_W'(1))) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      done_q   <= 1'b0;
      cand_q   <= '0;
    end else begin
      loaded_q <= loaded_d;
      done_q   <= done_d;
      cand_q   <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      arrival_q   <= wr_i.arrival;
      burst_q     <= wr_i.burst;
      remaining_q <= wr_i.burst;
      prio_q      <= wr_i.prio;
      first_run_q <= '0;
    end else if (run_i) begin
      if (remaining_q == burst_q) begin
        first_run_q <= time_i;
      end
      remaining_q <= remaining_q - TIME_W'(1);
    end
  end

  assign cand_o = cand_q;

endmodule
`default_nettype wire

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
`default_nettype none
// Channel   Direction  Handshake                 Payload
// item      in         start & !busy             item_i   (pps_pkg::item_t)
// result    out        valid_o, one cycle        result_o (pps_pkg::result_t)
//
// A load item writes its slot cell and leaves busy low. A tick item holds
// busy through ST_SCAN, ST_EVAL and ST_EMIT: the best-candidate token walks
// the row of slot cells one cell per cycle, then ST_EVAL and ST_EMIT form the
// timing figures, and the result strobes in the cycle busy falls.
// Reset clears the loaded and done flags, the clock and the controller.
// The receiver cannot stall: valid_o is high for exactly one cycle per tick.
module preemptive_priority_scheduler (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pps_pkg::item_t   item_i,
  output logic             valid_o,
  output pps_pkg::result_t result_o
);
  import pps_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] clock_q, clock_d;
  logic              accept, commit;

  cand_t             chain [NUM_PROCS+1];
  logic [NUM_PROCS-1:0] idle_vec;
  cell_wr_t          wr;
  cand_t             win, win_q;
  logic [TIME_W-1:0] clock_inc;
  logic [TIME_W-1:0] first_q, tat_q, resp_q;
  logic              fin;
  logic              valid_q;
  result_t           result_q;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign valid_o = valid_q;
  assign result_o = result_q;

  // Shared slot write; each cell's enable is gated by its own slot index.
  assign wr.en      = accept && (item_i.operation == OP_LOAD);
  assign wr.arrival = item_i.arrival_time;
  assign wr.burst   = item_i.burst_time;
  assign wr.prio    = item_i.priority_req;

  assign chain[0] = '0;
  assign win      = chain[NUM_PROCS];
  // The last cell holds the full sweep when cnt_q reaches NUM_PROCS.
  assign commit   = (state_q == ST_SCAN) && (cnt_q == CNT_W'(NUM_PROCS));
  assign clock_inc = (clock_q < TIME_MAX) ? (clock_q + TIME_W'(1)) : TIME_MAX;

  for (genvar i = 0; i < NUM_PROCS; i++) begin : g_cell
    cell_wr_t cwr;
    logic     run;
    always_comb begin
      cwr    = wr;
      cwr.en = wr.en && (32'(item_i.slot) == i);
    end
    assign run = commit && win.valid && (win.index == IDX_W'(i));
    pps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .wr_i       (cwr),
      .run_i      (run),
      .time_i     (clock_q),
      .cand_i     (chain[i]),
      .cand_o     (chain[i+1]),
      .idle_o     (idle_vec[i])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    clock_d = clock_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.operation == OP_TICK)) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (commit) begin
          state_d = ST_EVAL;
          clock_d = clock_inc;
        end
      end
      ST_EVAL: state_d = ST_EMIT;
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      clock_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clock_q <= clock_d;
      valid_q <= (state_q == ST_EMIT);
    end
  end

  assign fin = win_q.valid && (win_q.remaining == TIME_W'(1));

  always_ff @(posedge clk_i) begin
    // Latch the winner and its first run time at commit.
    if (commit) begin
      win_q   <= win;
      first_q <= (win.remaining == win.burst) ? clock_q : win.first_run;
    end
    // First subtraction stage.
    if (state_q == ST_EVAL) begin
      tat_q  <= sat_sub(clock_q, win_q.arrival);
      resp_q <= sat_sub(first_q, win_q.arrival);
    end
    // Second stage and output register.
    if (state_q == ST_EMIT) begin
      result_q.tick_ran        <= win_q.valid;
      result_q.process_slot    <= win_q.valid ? SLOT_W'(win_q.index) : '0;
      result_q.time_now        <= clock_q;
      result_q.finished        <= fin;
      result_q.completion_time <= fin ? clock_q : '0;
      result_q.turnaround_time <= fin ? tat_q : '0;
      result_q.waiting_time    <= fin ? sat_sub(tat_q, win_q.burst) : '0;
      result_q.response_time   <= fin ? resp_q : '0;
      result_q.all_done        <= &idle_vec;
    end
  end

endmodule
`default_nettype wire
